// ===== hdl/b64le_pkg.sv =====
// Shared types and constants for the base64 line encoder.
// Holds the request and result payloads, the job descriptor and the symbol map.
// No dependencies.
`default_nettype none

package b64le_pkg;

    localparam int MAX_CHARS = 6;
    localparam int JOB_QUEUE_DEPTH = 4;

    localparam logic [6:0] CHAR_CR = 7'd13;
    localparam logic [6:0] CHAR_LF = 7'd10;
    localparam logic [6:0] CHAR_PAD = 7'd61;
    localparam logic [6:0] CHAR_PLUS = 7'd43;
    localparam logic [6:0] CHAR_SLASH = 7'd47;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_final;
    } t_in_item;

    typedef struct packed {
        logic [6:0] out_char;
        logic       run_last;
    } t_out_item;

    typedef struct packed {
        logic [MAX_CHARS-1:0][6:0] chars;
        logic [2:0]                n_chars;
    } t_job;

    function automatic logic [6:0] sym_char(input logic [5:0] v);
        logic [6:0] c;
        if (v < 6'd26) begin
            c = 7'(v) + 7'd65;
        end else if (v < 6'd52) begin
            c = 7'(v) + 7'd71;
        end else if (v < 6'd62) begin
            c = 7'(v) - 7'd4;
        end else if (v == 6'd62) begin
            c = CHAR_PLUS;
        end else begin
            c = CHAR_SLASH;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/b64le_front.sv =====
// Front end: takes raw bytes, keeps group phase, carry and line count,
// and turns each byte into a job of up to six characters. Uses b64le_pkg.
`default_nettype none

module b64le_front
    import b64le_pkg::*;
#(
    parameter int BYTES_PER_LINE = 57
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_accept,
    input  wire t_in_item i_item,
    output t_job          o_job
);

    localparam int LW = $clog2(BYTES_PER_LINE + 1);

    logic [1:0]    r_phase, n_phase;
    logic [3:0]    r_carry, n_carry;
    logic [LW-1:0] r_count, n_count;
    logic [LW-1:0] w_inc;
    logic          w_line_end;
    logic [7:0]    w_b;
    logic [6:0]    w_s0, w_s1;

    assign w_b        = i_item.data_byte;
    assign w_inc      = r_count + LW'(1);
    assign w_line_end = i_item.is_final || (w_inc >= LW'(BYTES_PER_LINE));

    always_comb begin
        w_s0    = sym_char(w_b[7:2]);
        w_s1    = sym_char(w_b[5:0]);
        n_phase = r_phase;
        n_carry = r_carry;
        o_job   = '0;
        unique case (r_phase)
            2'd0: begin
                w_s0 = sym_char(w_b[7:2]);
                n_phase = 2'd1;
                n_carry = {2'b00, w_b[1:0]};
                o_job.chars[0] = w_s0;
                if (w_line_end) begin
                    o_job.chars[1] = sym_char({w_b[1:0], 4'b0000});
                    o_job.chars[2] = CHAR_PAD;
                    o_job.chars[3] = CHAR_PAD;
                    o_job.chars[4] = CHAR_CR;
                    o_job.chars[5] = CHAR_LF;
                    o_job.n_chars  = 3'd6;
                end else begin
                    o_job.n_chars = 3'd1;
                end
            end
            2'd1: begin
                w_s0 = sym_char({r_carry[1:0], w_b[7:4]});
                n_phase = 2'd2;
                n_carry = w_b[3:0];
                o_job.chars[0] = w_s0;
                if (w_line_end) begin
                    o_job.chars[1] = sym_char({w_b[3:0], 2'b00});
                    o_job.chars[2] = CHAR_PAD;
                    o_job.chars[3] = CHAR_CR;
                    o_job.chars[4] = CHAR_LF;
                    o_job.n_chars  = 3'd5;
                end else begin
                    o_job.n_chars = 3'd1;
                end
            end
            default: begin
                w_s0 = sym_char({r_carry, w_b[7:6]});
                n_phase = 2'd0;
                n_carry = 4'd0;
                o_job.chars[0] = w_s0;
                o_job.chars[1] = w_s1;
                if (w_line_end) begin
                    o_job.chars[2] = CHAR_CR;
                    o_job.chars[3] = CHAR_LF;
                    o_job.n_chars  = 3'd4;
                end else begin
                    o_job.n_chars = 3'd2;
                end
            end
        endcase
        n_count = w_inc;
        if (w_line_end) begin
            n_phase = 2'd0;
            n_carry = 4'd0;
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 2'd0;
            r_carry <= 4'd0;
            r_count <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_carry <= n_carry;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/b64le_fifo.sv =====
// Job queue between the front end and the character back end.
// Small register array with read and write pointers. Uses b64le_pkg.
`default_nettype none

module b64le_fifo
    import b64le_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_wr,
    input  wire t_job i_wr_job,
    input  wire logic i_rd,
    output t_job      o_rd_job,
    output logic      o_full,
    output logic      o_empty
);

    localparam int QW = $clog2(JOB_QUEUE_DEPTH);

    t_job          r_mem [JOB_QUEUE_DEPTH];
    logic [QW-1:0] r_wr_ptr;
    logic [QW-1:0] r_rd_ptr;
    logic [QW:0]   r_level;
    logic          w_wr, w_rd;

    assign o_full   = (r_level == (QW+1)'(JOB_QUEUE_DEPTH));
    assign o_empty  = (r_level == '0);
    assign w_wr     = i_wr && !o_full;
    assign w_rd     = i_rd && !o_empty;
    assign o_rd_job = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wr_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + QW'(1);
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + QW'(1);
            end
            unique case ({w_wr, w_rd})
                2'b10:   r_level <= r_level + (QW+1)'(1);
                2'b01:   r_level <= r_level - (QW+1)'(1);
                default: r_level <= r_level;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/b64le_back.sv =====
// Back end: walks the head job's characters into the result register one
// per cycle unless the consumer stalls, marking the last. Uses b64le_pkg.
`default_nettype none

module b64le_back
    import b64le_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_job i_job,
    input  wire logic i_job_valid,
    output logic      o_job_done,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_out_item o_item
);

    logic [2:0] r_idx, n_idx;
    logic       r_valid;
    t_out_item  r_out;
    logic       w_load, w_last;

    assign w_load     = i_job_valid && (!r_valid || i_pop);
    assign w_last     = (r_idx == (i_job.n_chars - 3'd1));
    assign o_job_done = w_load && w_last;
    assign n_idx      = w_last ? 3'd0 : r_idx + 3'd1;
    assign o_empty    = !r_valid;
    assign o_item     = r_out;

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.out_char <= i_job.chars[r_idx];
            r_out.run_last <= w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 3'd0;
            r_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_idx <= n_idx;
            end
            if (w_load) begin
                r_valid <= 1'b1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/base64_line_encoder_unit.sv =====
// Top level of the base64 line encoder: front end, job queue and back end.
// Uses b64le_pkg, b64le_front, b64le_fifo and b64le_back.
`default_nettype none

// One request is one raw byte; it yields one to six characters (base64
// symbols, '=' padding, CR LF at each line end and after the final byte).
// Requests are taken one per cycle while the four-entry job queue has room;
// the back end sends one character per cycle unless the consumer stalls,
// and a byte makes one or two characters in mid-line, four to six at a line
// end, about 1.4 on average. A byte's first character is registered in the
// job queue, then in the result register, which holds a character while
// the consumer stalls; requests keep flowing until the queue is full.
module base64_line_encoder_unit
    import b64le_pkg::*;
#(
    parameter int BYTES_PER_LINE = 57
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      push,
    output logic           full,
    input  wire t_in_item  i_in_item,
    output logic           empty,
    input  wire logic      pop,
    output t_out_item      o_out_item
);

    t_job w_front_job;
    t_job w_head_job;
    logic w_accept;
    logic w_q_empty;
    logic w_job_done;

    assign w_accept = push && !full;

    b64le_front #(
        .BYTES_PER_LINE(BYTES_PER_LINE)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(w_accept),
        .i_item  (i_in_item),
        .o_job   (w_front_job)
    );

    b64le_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_accept),
        .i_wr_job(w_front_job),
        .i_rd    (w_job_done),
        .o_rd_job(w_head_job),
        .o_full  (full),
        .o_empty (w_q_empty)
    );

    b64le_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (w_head_job),
        .i_job_valid(!w_q_empty),
        .o_job_done (w_job_done),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_item     (o_out_item)
    );

endmodule

`default_nettype wire

// ===== hdl/b64le_checker.sv =====
// Port-level checks for base64_line_encoder_unit, bound to the top level.
// Uses b64le_pkg.
`default_nettype none

module b64le_checker
    import b64le_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      push,
    input wire logic      full,
    input wire t_in_item  i_in_item,
    input wire logic      empty,
    input wire logic      pop,
    input wire t_out_item o_out_item
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not cleared by reset");

    a_req_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && full) |=> (push && $stable(i_in_item)))
        else $error("waiting request dropped or changed");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_item)))
        else $error("waiting result changed");

    a_cr_then_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && o_out_item.out_char == CHAR_CR) |=>
        (!empty && o_out_item.out_char == CHAR_LF && o_out_item.run_last))
        else $error("CR not followed by final LF");

    a_lf_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_item.out_char == CHAR_LF) |-> o_out_item.run_last)
        else $error("LF not marked last");

endmodule

bind base64_line_encoder_unit b64le_checker u_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .push      (push),
    .full      (full),
    .i_in_item (i_in_item),
    .empty     (empty),
    .pop       (pop),
    .o_out_item(o_out_item)
);

`default_nettype wire
